>>> rtl/core/arm_pkg.sv
// ---------------------------------------------------------------------------
// arm_pkg
// Shared types and constants for the address range merge table.
// ---------------------------------------------------------------------------
`default_nettype none
package arm_pkg;

    localparam int ADDR_BITS_DEF  = 16;
    localparam int MAX_RANGES_DEF = 16;

    typedef enum logic [1:0] {
        OP_MARK   = 2'd0,
        OP_SET    = 2'd1,
        OP_REWIND = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN2,
        ST_SHIFT,
        ST_STAT,
        ST_CUR,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/address_range_merge_table.sv
// ---------------------------------------------------------------------------
// address_range_merge_table
// Table of covered address ranges with mark, set, rewind and find.
// ---------------------------------------------------------------------------
// channel   dir  beat
// s_axis    in   opcode, address, span_end
// m_axis    out  current range, extremes, count, find result, overflow
//
// The cost of a beat lies in the scans over the range memory, one entry read per
// cycle, and in the entries moved while the table compacts after a join; each
// move reads an entry and then writes it one place lower.
// Reset clears count and selection at once; no clearing pass. The input is
// held off until the result is taken; a stalled result holds.
`default_nettype none
module address_range_merge_table
#(
    parameter int ADDR_BITS  = arm_pkg::ADDR_BITS_DEF,
    parameter int MAX_RANGES = arm_pkg::MAX_RANGES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // opcode[1:0], address[17:2], span_end[33:18]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata    // cur_start[15:0], cur_end[31:16],
                                             // cur_address[47:32], cur_valid[48],
                                             // found[49], found_index[53:50],
                                             // lowest_start[69:54], highest_end[85:70],
                                             // range_count[90:86], overflow[91]
);
    import arm_pkg::*;

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);
    localparam logic [ADDR_BITS-1:0] ONES = '1;

    logic [ADDR_BITS-1:0] mem_first [MAX_RANGES];
    logic [ADDR_BITS-1:0] mem_last  [MAX_RANGES];

    state_t state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [ADDR_BITS-1:0] a_reg, a_next, e_reg, e_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        cidx_reg, cidx_next;
    logic                 csel_reg, csel_next;
    logic [ADDR_BITS-1:0] caddr_reg, caddr_next;
    logic [CW-1:0]        k_reg, k_next;       // scan index
    logic                 rv_reg, rv_next;     // read data valid this cycle
    logic [IW-1:0]        ri_reg, ri_next;     // index of read data
    logic                 fnd_reg, fnd_next, ovf_reg, ovf_next, have_reg, have_next;
    logic [IW-1:0]        fidx_reg, fidx_next;
    logic [IW-1:0]        hit_reg, hit_next;   // first touching entry i
    logic                 hleft_reg, hleft_next; // i touches on its left side
    logic [ADDR_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [ADDR_BITS-1:0] cs_reg, cs_next, ce_reg, ce_next;
    logic [95:0]          obuf_reg, obuf_next;
    logic                 ov_reg, ov_next;

    // memory port
    logic [IW-1:0]        rd_addr;
    logic [ADDR_BITS-1:0] rd_first, rd_last;
    logic                 wr_en, wrl_en;
    logic [IW-1:0]        wr_addr;
    logic [ADDR_BITS-1:0] wr_first, wr_last;

    always_ff @(posedge clk)
    begin
        rd_first <= mem_first[rd_addr];
        rd_last  <= mem_last[rd_addr];
        if (wr_en)
        begin
            mem_first[wr_addr] <= wr_first;
        end
        if (wrl_en)
        begin
            mem_last[wr_addr] <= wr_last;
        end
    end

    logic in_f, t_left, t_right, cov;
    always_comb
    begin
        in_f    = (rd_first <= a_reg) && (a_reg <= rd_last);
        t_left  = ({1'b0, a_reg} + 1'b1) == {1'b0, rd_first};
        t_right = ({1'b0, rd_last} + 1'b1) == {1'b0, a_reg};
        cov     = (rd_first <= a_reg) && (e_reg <= rd_last);
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; a_next = a_reg; e_next = e_reg;
        cnt_next = cnt_reg; cidx_next = cidx_reg; csel_next = csel_reg;
        caddr_next = caddr_reg; k_next = k_reg; rv_next = 1'b0; ri_next = ri_reg;
        fnd_next = fnd_reg; ovf_next = ovf_reg; have_next = have_reg;
        fidx_next = fidx_reg; hit_next = hit_reg; hleft_next = hleft_reg;
        lo_next = lo_reg; hi_next = hi_reg; cs_next = cs_reg; ce_next = ce_reg;
        obuf_next = obuf_reg; ov_next = ov_reg;
        rd_addr = k_reg[IW-1:0];
        wr_en = 1'b0; wrl_en = 1'b0; wr_addr = '0; wr_first = a_reg; wr_last = a_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = !ov_reg;
                if (s_axis_tvalid && !ov_reg)
                begin
                    op_next  = s_axis_tdata[1:0];
                    a_next   = ADDR_BITS'(s_axis_tdata[17:2]);
                    e_next   = ADDR_BITS'(s_axis_tdata[33:18]);
                    k_next   = '0;
                    fnd_next = 1'b0; ovf_next = 1'b0; fidx_next = '0; have_next = 1'b0;
                    case (op_t'(s_axis_tdata[1:0]))
                        OP_MARK:
                        begin
                            caddr_next = ADDR_BITS'(s_axis_tdata[17:2]);
                            state_next = ST_SCAN;
                        end
                        OP_SET:
                        begin
                            caddr_next = ADDR_BITS'(s_axis_tdata[17:2]);
                            state_next = ST_STAT;
                        end
                        OP_REWIND:
                        begin
                            caddr_next = ONES;
                            csel_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue read k, evaluate previous
                rd_addr = k_reg[IW-1:0];
                if (k_reg < cnt_reg)
                begin
                    rv_next = 1'b1;
                    ri_next = k_reg[IW-1:0];
                    k_next  = k_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    case (op_t'(op_reg))
                        OP_MARK:
                        begin
                            if (in_f)
                            begin
                                cidx_next = ri_reg; csel_next = 1'b1;
                                rv_next = 1'b0; state_next = ST_STAT;
                            end
                            else if (t_left || t_right)
                            begin
                                hit_next = ri_reg; hleft_next = t_left;
                                cs_next = rd_first; ce_next = rd_last;
                                rv_next = 1'b0; k_next = '0;
                                state_next = ST_SCAN2;
                            end
                        end
                        OP_REWIND:
                        begin
                            if (!have_reg || rd_first < caddr_reg)
                            begin
                                have_next = 1'b1; caddr_next = rd_first;
                                cidx_next = ri_reg; csel_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (cov && !fnd_reg)
                            begin
                                fnd_next = 1'b1; fidx_next = ri_reg;
                            end
                        end
                    endcase
                end
                if (state_next == ST_SCAN && !rv_next && !(rv_reg && k_reg < cnt_reg))
                begin
                    if (op_reg == OP_MARK)
                    begin
                        if (cnt_reg >= MAXC)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            wr_en = 1'b1; wrl_en = 1'b1; wr_addr = cnt_reg[IW-1:0];
                            cidx_next = cnt_reg[IW-1:0]; csel_next = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    state_next = ST_STAT;
                end
            end
            ST_SCAN2:
            begin
                // search partner j that touches the other side
                rd_addr = k_reg[IW-1:0];
                if (k_reg < cnt_reg)
                begin
                    rv_next = 1'b1; ri_next = k_reg[IW-1:0]; k_next = k_reg + 1'b1;
                end
                if (rv_reg && ri_reg != hit_reg && (hleft_reg ? t_right : t_left))
                begin
                    rv_next = 1'b0;
                    wr_en = hleft_reg; wrl_en = !hleft_reg;
                    if (hit_reg < ri_reg)
                    begin
                        wr_addr = hit_reg; wr_first = rd_first; wr_last = rd_last;
                        cidx_next = hit_reg;
                    end
                    else
                    begin
                        wr_en = !hleft_reg; wrl_en = hleft_reg;
                        wr_addr = ri_reg; wr_first = cs_reg; wr_last = ce_reg;
                        cidx_next = ri_reg;
                    end
                    csel_next = 1'b1;
                    k_next = {1'b0, (hit_reg < ri_reg) ? ri_reg : hit_reg} + 1'b1;
                    state_next = ST_SHIFT;
                end
                else if (!rv_next && !rv_reg)
                begin
                    wr_en = hleft_reg; wrl_en = !hleft_reg; wr_addr = hit_reg;
                    cidx_next = hit_reg; csel_next = 1'b1;
                    state_next = ST_STAT;
                end
            end
            ST_SHIFT:
            begin
                // move entry k-1 <- k, one entry at a time: read it, then write it
                rd_addr = k_reg[IW-1:0];
                if (rv_reg)
                begin
                    wr_en = 1'b1; wrl_en = 1'b1; wr_addr = ri_reg - 1'b1;
                    wr_first = rd_first; wr_last = rd_last;
                end
                if (k_reg < cnt_reg && !rv_reg)
                begin
                    rv_next = 1'b1; ri_next = k_reg[IW-1:0]; k_next = k_reg + 1'b1;
                end
                else if (!(k_reg < cnt_reg))
                begin
                    if (!rv_reg || k_reg >= cnt_reg)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        state_next = ST_STAT;
                    end
                end
            end
            ST_STAT:
            begin
                // extremes over the table
                rd_addr = k_reg[IW-1:0];
                if (!rv_reg && !have_reg)
                begin
                    k_next = '0; have_next = 1'b1; lo_next = '0; hi_next = '0;
                    state_next = ST_STAT;
                end
                else
                begin
                    if (k_reg < cnt_reg)
                    begin
                        rv_next = 1'b1; ri_next = k_reg[IW-1:0]; k_next = k_reg + 1'b1;
                    end
                    if (rv_reg)
                    begin
                        if (ri_reg == '0 || rd_first < lo_reg)
                        begin
                            lo_next = rd_first;
                        end
                        if (rd_last > hi_reg)
                        begin
                            hi_next = rd_last;
                        end
                    end
                    if (!rv_next && k_reg >= cnt_reg)
                    begin
                        if (csel_reg && {1'b0, cidx_reg} >= cnt_reg)
                        begin
                            csel_next = 1'b0;
                        end
                        state_next = ST_CUR;
                    end
                end
            end
            ST_CUR:
            begin
                rd_addr = cidx_reg;
                if (!rv_reg)
                begin
                    rv_next = 1'b1;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                obuf_next = {4'd0,
                             ovf_reg,
                             5'(cnt_reg),
                             16'(hi_reg),
                             16'(lo_reg),
                             4'(fidx_reg),
                             fnd_reg,
                             csel_reg,
                             16'(caddr_reg),
                             csel_reg ? 16'(rd_last) : 16'd0,
                             csel_reg ? 16'(rd_first) : 16'd0};
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_SCAN2 || state_reg == ST_SHIFT)
        begin
            have_next = 1'b0;
        end
        if (state_reg == ST_IDLE && state_next != ST_IDLE)
        begin
            have_next = 1'b0;
        end
        if (state_reg == ST_SCAN && state_next == ST_STAT)
        begin
            have_next = 1'b0;
        end
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            cidx_reg  <= '0;
            csel_reg  <= 1'b0;
            caddr_reg <= ONES;
            rv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cidx_reg  <= cidx_next;
            csel_reg  <= csel_next;
            caddr_reg <= caddr_next;
            rv_reg    <= rv_next;
            ov_reg    <= ov_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; a_reg <= a_next; e_reg <= e_next;
        k_reg <= k_next; ri_reg <= ri_next;
        fnd_reg <= fnd_next; ovf_reg <= ovf_next; fidx_reg <= fidx_next;
        hit_reg <= hit_next; hleft_reg <= hleft_next;
        lo_reg <= lo_next; hi_reg <= hi_next; cs_reg <= cs_next; ce_reg <= ce_next;
        obuf_reg <= obuf_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = obuf_reg;

endmodule
`default_nettype wire
